// ===== rtl/ntatc_pkg.sv =====
// Package: word types, token kinds, fault codes and lexer phases of the tokenizer checker.
package ntatc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [30:0] token_offset;
    logic [30:0] token_length;
    logic [30:0] token_line;
    logic [30:0] token_column;
    logic [7:0]  nest_level;
    logic [3:0]  error_code;
    logic        doc_done;
  } out_word_t;

  localparam logic [2:0] KIND_TAG   = 3'd0;
  localparam logic [2:0] KIND_TEXT  = 3'd1;
  localparam logic [2:0] KIND_MULTI = 3'd2;
  localparam logic [2:0] KIND_OPEN  = 3'd3;
  localparam logic [2:0] KIND_CLOSE = 3'd4;
  localparam logic [2:0] KIND_END   = 3'd5;
  localparam logic [2:0] KIND_ERROR = 3'd6;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_COMMENT     = 4'd1;
  localparam logic [3:0] ERR_OPEN_JUNK   = 4'd2;
  localparam logic [3:0] ERR_CLOSE_JUNK  = 4'd3;
  localparam logic [3:0] ERR_TEXT        = 4'd4;
  localparam logic [3:0] ERR_MLOPEN_JUNK = 4'd5;
  localparam logic [3:0] ERR_MLCLOSE_JUNK= 4'd6;
  localparam logic [3:0] ERR_MLTEXT      = 4'd7;
  localparam logic [3:0] ERR_UNTERM      = 4'd8;
  localparam logic [3:0] ERR_NO_VALUE    = 4'd9;
  localparam logic [3:0] ERR_MISS_CLOSE  = 4'd10;
  localparam logic [3:0] ERR_STRAY_CLOSE = 4'd11;
  localparam logic [3:0] ERR_TOO_DEEP    = 4'd12;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LBR   = 8'h7B;
  localparam logic [7:0] CH_RBR   = 8'h7D;
  localparam logic [7:0] CH_VIS_LO = 8'd33;
  localparam logic [7:0] CH_VIS_HI = 8'd126;

  typedef enum logic [11:0] {
    PH_IDLE    = 12'b0000_0000_0001,
    PH_COMMENT = 12'b0000_0000_0010,
    PH_TAG     = 12'b0000_0000_0100,
    PH_OPEN    = 12'b0000_0000_1000,
    PH_CLOSE   = 12'b0000_0001_0000,
    PH_QUOTE   = 12'b0000_0010_0000,
    PH_TEXT    = 12'b0000_0100_0000,
    PH_MLOPEN  = 12'b0000_1000_0000,
    PH_MLSTART = 12'b0001_0000_0000,
    PH_MLQUOTE = 12'b0010_0000_0000,
    PH_MLTEXT  = 12'b0100_0000_0000,
    PH_MLCLOSE = 12'b1000_0000_0000
  } phase_e;

  function automatic logic is_visible(input logic [7:0] b);
    return (b >= CH_VIS_LO) && (b <= CH_VIS_HI);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB);
  endfunction

  function automatic logic is_tagch(input logic [7:0] b);
    return (b == 8'h5F) || (b == CH_DOT) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h30) && (b <= 8'h39));
  endfunction

  function automatic out_word_t make_word(input logic [2:0] kind, input logic [30:0] off,
                                          input logic [30:0] len, input logic [30:0] ln,
                                          input logic [30:0] col, input logic [7:0] lvl,
                                          input logic [3:0] code);
    out_word_t w;
    w.token_kind   = kind;
    w.token_offset = off;
    w.token_length = len;
    w.token_line   = ln;
    w.token_column = col;
    w.nest_level   = lvl;
    w.error_code   = code;
    w.doc_done     = (kind == KIND_ERROR);
    return w;
  endfunction

endpackage

// ===== rtl/nested_text_array_tokenizer_checker.sv =====
// Top level: byte-serial lexer and grammar checker with a four-word result queue.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_word_i  (byte, final)
//  out     | output    | out_valid_o / out_stall_i | out_word_o (one token)
//  cfg     | input     | cfg_we_i                  | cfg_data_i (depth limit)
//
// One byte is taken each cycle while in_stall_o is low; its zero to two tokens are
// computed in the same cycle and written into a four-entry queue, which drains one
// word per cycle while out_stall_i is low. A token reaches out_word_o from the queue
// once the words ahead of it have drained. Input stalls while fewer than two queue
// entries are free. Reset clears the lexer state and queue and loads the depth limit with 128.
module nested_text_array_tokenizer_checker #(
  parameter int DepthMax = 255,
  parameter int PosBits  = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ntatc_pkg::in_word_t   in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ntatc_pkg::out_word_t  out_word_o,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_data_i
);

  localparam logic [30:0] PosMax   = 31'((64'd1 << PosBits) - 64'd1);
  localparam logic [7:0]  DepthCap = 8'(DepthMax);

  function automatic logic [30:0] sat_inc(input logic [30:0] v);
    return (v >= PosMax) ? PosMax : v + 31'd1;
  endfunction

  logic [7:0]        depth_limit_q;
  ntatc_pkg::phase_e ph_q, ph_d;
  logic [7:0]        dep_q, dep_d;
  logic              atf_q, atf_d;
  logic [30:0]       pos_q, pos_d, line_q, line_d, col_q, col_d;
  logic [30:0]       so_q, so_d, sl_q, sl_d, sc_q, sc_d, mle_q, mle_d;
  logic [1:0]        qr_q, qr_d;
  logic              err_q, err_d;

  ntatc_pkg::out_word_t res0, res1;
  logic [1:0]           nres;

  ntatc_pkg::out_word_t fifo_q [4];
  logic [1:0]           wr_q, rd_q;
  logic [2:0]           cnt_q;
  logic                 accept, pop;

  assign in_stall_o  = (cnt_q > 3'd2);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_word_o  = fifo_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    ntatc_pkg::out_word_t res [3];
    logic [1:0]  n;
    logic [7:0]  b;
    logic        fin, go, req;
    logic [2:0]  fk;
    logic [30:0] fe, cur, ln, col, ln_n, col_n, pos_n;
    logic [7:0]  cap;

    res[0] = '0; res[1] = '0; res[2] = '0;
    n = 2'd0;
    b = in_word_i.data_byte;
    fin = in_word_i.is_final;
    cap = (depth_limit_q > DepthCap) ? DepthCap : depth_limit_q;
    ph_d = ph_q; dep_d = dep_q; atf_d = atf_q;
    so_d = so_q; sl_d = sl_q; sc_d = sc_q; mle_d = mle_q; qr_d = qr_q; err_d = err_q;
    cur = pos_q; ln = line_q; col = col_q;
    pos_n = sat_inc(pos_q);
    ln_n  = (b == ntatc_pkg::CH_NL) ? sat_inc(line_q) : line_q;
    col_n = (b == ntatc_pkg::CH_NL) ? 31'd1 : sat_inc(col_q);
    go = 1'b1; req = 1'b0; fk = ntatc_pkg::KIND_TEXT; fe = '0;

    for (int pass = 0; pass < 2; pass++) begin
      req = 1'b0;
      if (pass == 0) begin
        if (!err_d) begin
          go = 1'b1;
          if (ph_d == ntatc_pkg::PH_TAG) begin
            if (!ntatc_pkg::is_tagch(b)) begin
              res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_TAG, so_d, cur - so_d, sl_d, sc_d,
                                            dep_d, ntatc_pkg::ERR_NONE);
              n = n + 2'd1;
              atf_d = 1'b1;
              ph_d = ntatc_pkg::PH_IDLE;
            end else begin
              go = 1'b0;
            end
          end else if (ph_d == ntatc_pkg::PH_QUOTE) begin
            if (b == ntatc_pkg::CH_QUOTE) begin
              qr_d = qr_d + 2'd1;
              if (qr_d == 2'd3) begin
                qr_d = 2'd0;
                ph_d = ntatc_pkg::PH_MLOPEN;
              end
              go = 1'b0;
            end else begin
              qr_d = 2'd0;
              ph_d = ntatc_pkg::PH_TEXT;
            end
          end
          if (go) begin
            case (ph_d)
              ntatc_pkg::PH_COMMENT: begin
                if (b == ntatc_pkg::CH_NL) begin
                  ph_d = ntatc_pkg::PH_IDLE;
                end else if (!ntatc_pkg::is_visible(b) && !ntatc_pkg::is_blank(b)) begin
                  res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, cur, '0, ln, col, dep_d,
                                                ntatc_pkg::ERR_COMMENT);
                  n = n + 2'd1; err_d = 1'b1;
                end
              end
              ntatc_pkg::PH_OPEN, ntatc_pkg::PH_CLOSE: begin
                if (b == ntatc_pkg::CH_NL) begin
                  req = 1'b1; fe = cur;
                  fk = (ph_d == ntatc_pkg::PH_OPEN) ? ntatc_pkg::KIND_OPEN : ntatc_pkg::KIND_CLOSE;
                  ph_d = ntatc_pkg::PH_IDLE;
                end else if (!ntatc_pkg::is_blank(b)) begin
                  res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, cur, '0, ln, col, dep_d,
                             (ph_d == ntatc_pkg::PH_OPEN) ? ntatc_pkg::ERR_OPEN_JUNK
                                                          : ntatc_pkg::ERR_CLOSE_JUNK);
                  n = n + 2'd1; err_d = 1'b1;
                end
              end
              ntatc_pkg::PH_TEXT: begin
                if (b == ntatc_pkg::CH_NL) begin
                  ph_d = ntatc_pkg::PH_IDLE;
                  req = 1'b1; fk = ntatc_pkg::KIND_TEXT; fe = cur;
                end else if (!ntatc_pkg::is_visible(b) && !ntatc_pkg::is_blank(b)) begin
                  res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, cur, '0, ln, col, dep_d,
                                                ntatc_pkg::ERR_TEXT);
                  n = n + 2'd1; err_d = 1'b1;
                end
              end
              ntatc_pkg::PH_MLOPEN: begin
                if (b == ntatc_pkg::CH_NL) begin
                  so_d = sat_inc(cur); sl_d = sat_inc(ln); sc_d = 31'd1;
                  mle_d = so_d;
                  ph_d = ntatc_pkg::PH_MLSTART;
                end else if (!ntatc_pkg::is_blank(b)) begin
                  res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, cur, '0, ln, col, dep_d,
                                                ntatc_pkg::ERR_MLOPEN_JUNK);
                  n = n + 2'd1; err_d = 1'b1;
                end
              end
              ntatc_pkg::PH_MLSTART, ntatc_pkg::PH_MLQUOTE, ntatc_pkg::PH_MLTEXT: begin
                if (b == ntatc_pkg::CH_NL) begin
                  mle_d = cur; qr_d = 2'd0; ph_d = ntatc_pkg::PH_MLSTART;
                end else if (b == ntatc_pkg::CH_QUOTE && ph_d != ntatc_pkg::PH_MLTEXT) begin
                  qr_d = (ph_d == ntatc_pkg::PH_MLSTART) ? 2'd1 : qr_d + 2'd1;
                  ph_d = ntatc_pkg::PH_MLQUOTE;
                  if (qr_d == 2'd3) begin
                    qr_d = 2'd0; ph_d = ntatc_pkg::PH_MLCLOSE;
                  end
                end else if (ntatc_pkg::is_blank(b)) begin
                  if (ph_d == ntatc_pkg::PH_MLQUOTE) begin
                    qr_d = 2'd0; ph_d = ntatc_pkg::PH_MLTEXT;
                  end
                end else if (ntatc_pkg::is_visible(b)) begin
                  qr_d = 2'd0; ph_d = ntatc_pkg::PH_MLTEXT;
                end else begin
                  res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, cur, '0, ln, col, dep_d,
                                                ntatc_pkg::ERR_MLTEXT);
                  n = n + 2'd1; err_d = 1'b1;
                end
              end
              ntatc_pkg::PH_MLCLOSE: begin
                if (b == ntatc_pkg::CH_NL) begin
                  ph_d = ntatc_pkg::PH_IDLE;
                  req = 1'b1; fk = ntatc_pkg::KIND_MULTI; fe = cur;
                end else if (!ntatc_pkg::is_blank(b)) begin
                  res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, cur, '0, ln, col, dep_d,
                                                ntatc_pkg::ERR_MLCLOSE_JUNK);
                  n = n + 2'd1; err_d = 1'b1;
                end
              end
              default: begin
                ph_d = ntatc_pkg::PH_IDLE;
                if (!ntatc_pkg::is_blank(b) && b != ntatc_pkg::CH_NL) begin
                  so_d = cur; sl_d = ln; sc_d = col;
                  if (!atf_d && b == ntatc_pkg::CH_HASH) begin
                    ph_d = ntatc_pkg::PH_COMMENT;
                  end else if (!atf_d && b == ntatc_pkg::CH_DOT) begin
                    ph_d = ntatc_pkg::PH_TAG;
                  end else if (b == ntatc_pkg::CH_LBR) begin
                    ph_d = ntatc_pkg::PH_OPEN;
                  end else if (b == ntatc_pkg::CH_RBR) begin
                    ph_d = ntatc_pkg::PH_CLOSE;
                  end else if (b == ntatc_pkg::CH_QUOTE) begin
                    qr_d = 2'd1; ph_d = ntatc_pkg::PH_QUOTE;
                  end else begin
                    ph_d = ntatc_pkg::PH_TEXT;
                    if (!ntatc_pkg::is_visible(b)) begin
                      res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, cur, '0, ln, col,
                                                    dep_d, ntatc_pkg::ERR_TEXT);
                      n = n + 2'd1; err_d = 1'b1;
                    end
                  end
                end
              end
            endcase
          end
        end
      end else if (fin && !err_d) begin
        fe = pos_n;
        case (ph_d)
          ntatc_pkg::PH_TAG: begin
            res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_TAG, so_d, pos_n - so_d, sl_d, sc_d,
                                          dep_d, ntatc_pkg::ERR_NONE);
            n = n + 2'd1;
            atf_d = 1'b1;
          end
          ntatc_pkg::PH_OPEN: begin
            req = 1'b1; fk = ntatc_pkg::KIND_OPEN;
          end
          ntatc_pkg::PH_CLOSE: begin
            req = 1'b1; fk = ntatc_pkg::KIND_CLOSE;
          end
          ntatc_pkg::PH_QUOTE, ntatc_pkg::PH_TEXT: begin
            req = 1'b1; fk = ntatc_pkg::KIND_TEXT;
          end
          ntatc_pkg::PH_MLCLOSE: begin
            req = 1'b1; fk = ntatc_pkg::KIND_MULTI;
          end
          ntatc_pkg::PH_MLOPEN, ntatc_pkg::PH_MLSTART, ntatc_pkg::PH_MLQUOTE,
          ntatc_pkg::PH_MLTEXT: begin
            res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, pos_n, '0, ln_n, col_n, dep_d,
                                          ntatc_pkg::ERR_UNTERM);
            n = n + 2'd1; err_d = 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (req) begin
        if (fk == ntatc_pkg::KIND_CLOSE) begin
          if (atf_d || dep_d == 8'd0) begin
            res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, so_d, '0, sl_d, sc_d, dep_d,
                       atf_d ? ntatc_pkg::ERR_NO_VALUE : ntatc_pkg::ERR_STRAY_CLOSE);
            n = n + 2'd1; err_d = 1'b1;
          end else begin
            dep_d = dep_d - 8'd1;
            res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_CLOSE, so_d, fe - so_d, sl_d, sc_d,
                                          dep_d, ntatc_pkg::ERR_NONE);
            n = n + 2'd1;
          end
        end else if (fk == ntatc_pkg::KIND_OPEN && ({1'b0, dep_d} + 9'd1 >= {1'b0, cap})) begin
          res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, so_d, '0, sl_d, sc_d, dep_d,
                                        ntatc_pkg::ERR_TOO_DEEP);
          n = n + 2'd1; err_d = 1'b1;
        end else begin
          if (fk == ntatc_pkg::KIND_OPEN) dep_d = dep_d + 8'd1;
          atf_d = 1'b0;
          res[n] = ntatc_pkg::make_word(fk, so_d,
                     (fk == ntatc_pkg::KIND_MULTI) ? ((mle_d >= so_d) ? mle_d - so_d : '0)
                                                   : fe - so_d,
                     sl_d, sc_d, dep_d, ntatc_pkg::ERR_NONE);
          n = n + 2'd1;
        end
      end

      if (pass == 1 && fin && !err_d) begin
        if (atf_d) begin
          res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, pos_n, '0, ln_n, col_n, dep_d,
                                        ntatc_pkg::ERR_NO_VALUE);
          err_d = 1'b1;
        end else if (dep_d != 8'd0) begin
          res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_ERROR, pos_n, '0, ln_n, col_n, dep_d,
                                        ntatc_pkg::ERR_MISS_CLOSE);
          err_d = 1'b1;
        end else begin
          res[n] = ntatc_pkg::make_word(ntatc_pkg::KIND_END, pos_n, '0, ln_n, col_n, dep_d,
                                        ntatc_pkg::ERR_NONE);
        end
        n = n + 2'd1;
      end
    end

    if (n == 2'd3) begin
      if (res[2].token_kind != ntatc_pkg::KIND_END) res[1] = res[2];
      n = 2'd2;
    end
    if (fin && n == 2'd1) res[0].doc_done = 1'b1;
    if (fin && n == 2'd2) res[1].doc_done = 1'b1;

    pos_d = pos_n; line_d = ln_n; col_d = col_n;
    if (fin) begin
      ph_d = ntatc_pkg::PH_IDLE; dep_d = '0; atf_d = 1'b0;
      pos_d = '0; line_d = 31'd1; col_d = 31'd1;
      so_d = '0; sl_d = 31'd1; sc_d = 31'd1; qr_d = '0; mle_d = '0; err_d = 1'b0;
    end
    res0 = res[0];
    res1 = res[1];
    nres = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_limit_q <= 8'd128;
      ph_q <= ntatc_pkg::PH_IDLE;
      dep_q <= '0; atf_q <= 1'b0;
      pos_q <= '0; line_q <= 31'd1; col_q <= 31'd1;
      so_q <= '0; sl_q <= 31'd1; sc_q <= 31'd1;
      qr_q <= '0; mle_q <= '0; err_q <= 1'b0;
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (cfg_we_i) depth_limit_q <= cfg_data_i;
      if (accept) begin
        ph_q <= ph_d; dep_q <= dep_d; atf_q <= atf_d;
        pos_q <= pos_d; line_q <= line_d; col_q <= col_d;
        so_q <= so_d; sl_q <= sl_d; sc_q <= sc_d;
        qr_q <= qr_d; mle_q <= mle_d; err_q <= err_d;
        wr_q <= wr_q + nres;
      end
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + (accept ? {1'b0, nres} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && nres != 2'd0) fifo_q[wr_q] <= res0;
    if (accept && nres == 2'd2) fifo_q[wr_q + 2'd1] <= res1;
  end

endmodule
